### src/fl_pkg.sv
package fl_pkg;
  localparam int POOL_PAGES = 64;
  localparam int ENTRIES = 512;
  localparam int PAGE_W = $clog2(POOL_PAGES);
  localparam int DEPTH = POOL_PAGES * ENTRIES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W = 9;
  localparam int NFP_W = $clog2(POOL_PAGES + 1);

  localparam logic [63:0] ADDR_MASK = 64'hFFFF_FFFF_FFFF_F000;
  localparam logic [63:0] FLAG_P = 64'h1;
  localparam logic [63:0] FLAG_RW = 64'h2;
  localparam logic [63:0] FLAG_U = 64'h4;
  localparam logic [63:0] FLAG_NX = 64'h8000_0000_0000_0000;

  localparam logic [1:0] ACT_MAP = 2'd0;
  localparam logic [1:0] ACT_UNMAP = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_NOPAGE = 2'd2;
  localparam logic [1:0] ST_OUTSIDE = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_WAIT, S_CHECK, S_ZERO, S_LINK, S_LEAF, S_LREAD, S_LWAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic we;
    logic [ADDR_W-1:0] waddr;
    logic [63:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;
endpackage

### src/fl_ram.sv
module fl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/fl_walker.sv
module fl_walker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [47:0]        virtual_address,
  input  logic [51:0]        frame_address,
  input  logic               user_access,
  input  logic               no_execute,
  input  logic [39:0]        base,
  input  logic [63:0]        rdata,
  output fl_pkg::mem_req_t   mreq,
  output logic               done,
  output logic [63:0]        entry,
  output logic [1:0]         status,
  output logic               invalidate
);
  import fl_pkg::*;

  state_t state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic [1:0] lvl, lvl_next;
  logic [PAGE_W-1:0] page, page_next;
  logic [PAGE_W-1:0] np, np_next;
  logic [NFP_W-1:0] nfp, nfp_next;
  logic [1:0] act;
  logic [47:0] va;
  logic [51:0] pa;
  logic ub, nx;
  logic [63:0] res, res_next;
  logic [1:0] st, st_next;
  logic inv, inv_next;
  logic [IDX_W-1:0] idx;
  logic [39:0] rel;
  logic [39:0] npfr;

  always_comb begin
    case (lvl)
      2'd0: idx = va[47:39];
      2'd1: idx = va[38:30];
      2'd2: idx = va[29:21];
      default: idx = va[20:12];
    endcase
  end

  assign rel = rdata[51:12] - base;
  assign npfr = base + 40'(np);
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      nfp <= NFP_W'(1);
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      nfp <= nfp_next;
    end
    lvl <= lvl_next;
    page <= page_next;
    np <= np_next;
    res <= res_next;
    st <= st_next;
    inv <= inv_next;
    if (start && !busy) begin
      act <= action;
      va <= virtual_address;
      pa <= frame_address;
      ub <= user_access;
      nx <= no_execute;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    lvl_next = lvl;
    page_next = page;
    np_next = np;
    nfp_next = nfp;
    res_next = res;
    st_next = st;
    inv_next = inv;
    mreq = '0;
    mreq.raddr = {page, idx};
    done = 1'b0;
    case (state)
      S_CLEAR: begin
        // sweep the whole store to zero after reset
        mreq.we = 1'b1;
        mreq.waddr = cnt;
        cnt_next = cnt + 1'b1;
        if (cnt == ADDR_W'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        lvl_next = '0;
        page_next = '0;
        res_next = '0;
        st_next = ST_DONE;
        inv_next = 1'b0;
        if (start) begin
          state_next = (action == ACT_NONE) ? S_DONE : S_READ;
        end
      end
      S_READ: state_next = S_WAIT;
      S_WAIT: state_next = S_CHECK;
      S_CHECK: begin
        if (!rdata[0]) begin
          if (act != ACT_MAP) begin
            st_next = ST_ABSENT;
            state_next = S_DONE;
          end else if (nfp >= NFP_W'(POOL_PAGES)) begin
            st_next = ST_NOPAGE;
            state_next = S_DONE;
          end else begin
            np_next = nfp[PAGE_W-1:0];
            nfp_next = nfp + 1'b1;
            cnt_next = '0;
            state_next = S_ZERO;
          end
        end else if (rel >= 40'(POOL_PAGES)) begin
          st_next = ST_OUTSIDE;
          state_next = S_DONE;
        end else begin
          page_next = rel[PAGE_W-1:0];
          lvl_next = lvl + 1'b1;
          state_next = (lvl == 2'd2) ? S_LEAF : S_READ;
        end
      end
      S_ZERO: begin
        // clear the new table one entry a cycle
        mreq.we = 1'b1;
        mreq.waddr = {np, cnt[IDX_W-1:0]};
        cnt_next = cnt + 1'b1;
        if (cnt[IDX_W-1:0] == IDX_W'(ENTRIES - 1)) state_next = S_LINK;
      end
      S_LINK: begin
        mreq.we = 1'b1;
        mreq.waddr = {page, idx};
        mreq.wdata = {12'd0, npfr, 12'd0} | FLAG_P | FLAG_RW | (ub ? FLAG_U : 64'd0);
        page_next = np;
        lvl_next = lvl + 1'b1;
        state_next = (lvl == 2'd2) ? S_LEAF : S_READ;
      end
      S_LEAF: begin
        if (act == ACT_MAP) begin
          mreq.we = 1'b1;
          mreq.waddr = {page, idx};
          mreq.wdata = ({12'd0, pa} & ADDR_MASK) | (ub ? FLAG_U : 64'd0)
                       | (nx ? FLAG_NX : 64'd0) | FLAG_P | FLAG_RW;
          res_next = mreq.wdata;
          inv_next = 1'b1;
          state_next = S_DONE;
        end else if (act == ACT_UNMAP) begin
          mreq.we = 1'b1;
          mreq.waddr = {page, idx};
          inv_next = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_LWAIT;
        end
      end
      S_LREAD: state_next = S_LWAIT;
      S_LWAIT: begin
        res_next = rdata;
        state_next = S_DONE;
      end
      S_DONE: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign entry = res;
  assign status = st;
  assign invalidate = inv;
endmodule

### src/four_level_page_table_engine_top.sv
// channel   | signals                                               | handshake
// request   | action virtual_address frame_address user_access no_execute | start & !busy
// result    | entry status invalidate                               | done (one cycle)
// config    | pool_base_frame_data                                  | pool_base_frame_we
// After reset a clearing pass zeroes the whole table store; busy is high meanwhile.
// Each level walks through address, registered RAM read and check.
// A walk that stops early answers in the cycle after the failing check.
// Each table a map allocates is cleared through the single RAM write port and then
// linked. busy drops after done and stays low while the engine is idle.
// Results cannot be stalled; done pulses once per request.
module four_level_page_table_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [47:0] virtual_address,
  input  logic [51:0] frame_address,
  input  logic        user_access,
  input  logic        no_execute,
  input  logic        pool_base_frame_we,
  input  logic [39:0] pool_base_frame_data,
  output logic        done,
  output logic [63:0] entry,
  output logic [1:0]  status,
  output logic        invalidate
);
  import fl_pkg::*;

  logic [39:0] base;
  mem_req_t mreq;
  logic [63:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (pool_base_frame_we) begin
      base <= pool_base_frame_data;
    end
  end

  fl_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(mreq.we), .waddr(mreq.waddr), .wdata(mreq.wdata),
    .raddr(mreq.raddr), .rdata(rdata)
  );

  fl_walker u_walk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .virtual_address(virtual_address), .frame_address(frame_address),
    .user_access(user_access), .no_execute(no_execute), .base(base),
    .rdata(rdata), .mreq(mreq), .done(done), .entry(entry), .status(status),
    .invalidate(invalidate)
  );

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result without request in flight");
  a_inv_ok: assert property (@(posedge clk) disable iff (rst)
    done && invalidate |-> status == ST_DONE)
    else $error("invalidate with failing status");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
`endif
endmodule
